FILE: hdl/rrts_pkg.sv
// Package for the round-robin time-slice scheduler.
// Holds sizes, request/result codes and the controller/datapath structs.
// No dependencies.
package rrts_pkg;

   localparam int TASK_SLOTS = 16;
   localparam int SLOT_W     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam int CNT_W      = $clog2(TASK_SLOTS + 1);

   // Field widths of the channels
   localparam int REQ_TYPE_W = 3;
   localparam int SLOT_FLD_W = 4;
   localparam int STATE_W    = 2;
   localparam int KIND_W     = 2;
   localparam int SLICE_W    = 8;

   localparam logic [SLICE_W-1:0] SLICE_RESET = 8'd10;

   // Request codes
   localparam logic [REQ_TYPE_W-1:0] REQ_ADD     = 3'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_START   = 3'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_TICK    = 3'd2;
   localparam logic [REQ_TYPE_W-1:0] REQ_SET     = 3'd3;
   localparam logic [REQ_TYPE_W-1:0] REQ_RESCHED = 3'd4;

   // Task states
   localparam logic [STATE_W-1:0] ST_READY   = 2'd0;
   localparam logic [STATE_W-1:0] ST_RUNNING = 2'd1;
   localparam logic [STATE_W-1:0] ST_DEAD    = 2'd2;

   // Event kinds
   localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SWITCH = 2'd1;
   localparam logic [KIND_W-1:0] KIND_START  = 2'd2;

   // Result selects
   localparam logic [2:0] RES_IGNORE = 3'd0;
   localparam logic [2:0] RES_ADD    = 3'd1;
   localparam logic [2:0] RES_START  = 3'd2;
   localparam logic [2:0] RES_HOLD   = 3'd3;
   localparam logic [2:0] RES_SET    = 3'd4;
   localparam logic [2:0] RES_SWITCH = 3'd5;

   // Table write selects
   localparam logic [2:0] WR_ADD        = 3'd0;
   localparam logic [2:0] WR_SET        = 3'd1;
   localparam logic [2:0] WR_START      = 3'd2;
   localparam logic [2:0] WR_PREV_READY = 3'd3;
   localparam logic [2:0] WR_NEXT_RUN   = 3'd4;

   // Table read selects
   localparam logic RD_SCAN_NEXT = 1'b0;
   localparam logic RD_CUR       = 1'b1;

   typedef struct packed {
      logic       load_req;
      logic       tick_upd;
      logic       start_upd;
      logic       scan_init;
      logic       scan_adv;
      logic       rd_en;
      logic       rd_src;
      logic       wr_en;
      logic [2:0] wr_sel;
      logic       res_en;
      logic [2:0] res_sel;
      logic       commit;
      logic       push;
   } cmd_type;

   typedef struct packed {
      logic [REQ_TYPE_W-1:0] req_type;
      logic                  full;
      logic                  empty;
      logic                  slot_ok;
      logic                  running;
      logic                  tick_expire;
      logic                  can_sched;
      logic                  scan_wraps_cur;
      logic                  rd_dead;
      logic                  rd_running;
      logic                  out_free;
   } sts_type;

endpackage

FILE: hdl/rrts_ifs.sv
// Valid/ready channel interfaces for scheduler requests and results.
// Depends on rrts_pkg for field widths.
interface rrts_req_if;
   import rrts_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [REQ_TYPE_W-1:0] req_type;
   logic [SLOT_FLD_W-1:0] slot;
   logic [STATE_W-1:0]    new_state;
   modport source (output valid, req_type, slot, new_state, input ready);
   modport sink   (input valid, req_type, slot, new_state, output ready);
endinterface

interface rrts_rsp_if;
   import rrts_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [KIND_W-1:0]     event_kind;
   logic [SLOT_FLD_W-1:0] from_slot;
   logic [SLOT_FLD_W-1:0] to_slot;
   logic                  status;
   modport source (output valid, event_kind, from_slot, to_slot, status, input ready);
   modport sink   (input valid, event_kind, from_slot, to_slot, status, output ready);
endinterface

FILE: hdl/rrts_ctrl.sv
// Scheduler controller: sequences decode, round-robin scan and table update.
// Depends on rrts_pkg; drives cmd_type to the datapath, reads sts_type.
module rrts_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rrts_pkg::sts_type sts,
   output rrts_pkg::cmd_type cmd
);
   import rrts_pkg::*;

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_DECODE    = 3'd1;
   localparam logic [2:0] S_SCAN_STEP = 3'd2;
   localparam logic [2:0] S_SCAN_CHK  = 3'd3;
   localparam logic [2:0] S_PREV_CHK  = 3'd4;
   localparam logic [2:0] S_COMMIT    = 3'd5;
   localparam logic [2:0] S_FINISH    = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       sched_begin;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd         = '0;
      state_in    = state_ff;
      sched_begin = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.res_en = 1'b1;
            state_in   = S_FINISH;
            unique case (sts.req_type)
               REQ_ADD: begin
                  if (sts.full) begin
                     cmd.res_sel = RES_IGNORE;
                  end else begin
                     cmd.wr_en   = 1'b1;
                     cmd.wr_sel  = WR_ADD;
                     cmd.res_sel = RES_ADD;
                  end
               end
               REQ_START: begin
                  if (sts.empty) begin
                     cmd.res_sel = RES_IGNORE;
                  end else begin
                     cmd.start_upd = 1'b1;
                     cmd.wr_en     = 1'b1;
                     cmd.wr_sel    = WR_START;
                     cmd.res_sel   = RES_START;
                  end
               end
               REQ_TICK: begin
                  if (!sts.running) begin
                     cmd.res_sel = RES_IGNORE;
                  end else begin
                     cmd.tick_upd = 1'b1;
                     if (sts.tick_expire) begin
                        sched_begin = 1'b1;
                     end else begin
                        cmd.res_sel = RES_HOLD;
                     end
                  end
               end
               REQ_SET: begin
                  if (!sts.slot_ok) begin
                     cmd.res_sel = RES_IGNORE;
                  end else begin
                     cmd.wr_en   = 1'b1;
                     cmd.wr_sel  = WR_SET;
                     cmd.res_sel = RES_SET;
                  end
               end
               REQ_RESCHED: begin
                  sched_begin = 1'b1;
               end
               default: begin
                  cmd.res_sel = RES_IGNORE;
               end
            endcase
            if (sched_begin) begin
               if (sts.can_sched) begin
                  cmd.res_en    = 1'b0;
                  cmd.scan_init = 1'b1;
                  state_in      = S_SCAN_STEP;
               end else begin
                  cmd.res_sel = RES_HOLD;
               end
            end
         end
         S_SCAN_STEP: begin
            if (sts.scan_wraps_cur) begin
               // every other slot is dead
               cmd.res_en  = 1'b1;
               cmd.res_sel = RES_HOLD;
               state_in    = S_FINISH;
            end else begin
               cmd.scan_adv = 1'b1;
               cmd.rd_en    = 1'b1;
               cmd.rd_src   = RD_SCAN_NEXT;
               state_in     = S_SCAN_CHK;
            end
         end
         S_SCAN_CHK: begin
            if (sts.rd_dead) begin
               state_in = S_SCAN_STEP;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_src = RD_CUR;
               state_in   = S_PREV_CHK;
            end
         end
         S_PREV_CHK: begin
            if (sts.rd_running) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = WR_PREV_READY;
            end
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = WR_NEXT_RUN;
            cmd.commit  = 1'b1;
            cmd.res_en  = 1'b1;
            cmd.res_sel = RES_SWITCH;
            state_in    = S_FINISH;
         end
         S_FINISH: begin
            if (sts.out_free) begin
               cmd.push = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

FILE: hdl/rrts_dpath.sv
// Scheduler datapath: task table memory, counters, scan pointer, result regs.
// Depends on rrts_pkg; driven by cmd_type from rrts_ctrl.
module rrts_dpath (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [rrts_pkg::REQ_TYPE_W-1:0] req_type,
   input  logic [rrts_pkg::SLOT_FLD_W-1:0] req_slot,
   input  logic [rrts_pkg::STATE_W-1:0]    req_new_state,
   input  logic                            csr_wr_en,
   input  logic [rrts_pkg::SLICE_W-1:0]    csr_wr_data,
   input  rrts_pkg::cmd_type               cmd,
   output rrts_pkg::sts_type               sts,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output logic [rrts_pkg::KIND_W-1:0]     rsp_event_kind,
   output logic [rrts_pkg::SLOT_FLD_W-1:0] rsp_from_slot,
   output logic [rrts_pkg::SLOT_FLD_W-1:0] rsp_to_slot,
   output logic                            rsp_status
);
   import rrts_pkg::*;

   localparam int WIDE_W = SLOT_W + SLOT_FLD_W;

   // latched request
   logic [REQ_TYPE_W-1:0] req_type_ff;
   logic [SLOT_FLD_W-1:0] slot_ff;
   logic [STATE_W-1:0]    new_state_ff;

   logic [CNT_W-1:0]   task_count_ff;
   logic [SLOT_W-1:0]  cur_ff;
   logic [SLICE_W-1:0] tick_ff;
   logic               run_ff;
   logic [SLICE_W-1:0] slice_ff;
   logic [SLOT_W-1:0]  scan_ff;

   logic [STATE_W-1:0] slot_state_mem [TASK_SLOTS];
   logic [STATE_W-1:0] rd_data_ff;

   logic [KIND_W-1:0]     res_kind_ff;
   logic [SLOT_FLD_W-1:0] res_from_ff;
   logic [SLOT_FLD_W-1:0] res_to_ff;
   logic                  res_status_ff;

   logic                  rsp_valid_ff;
   logic [KIND_W-1:0]     out_kind_ff;
   logic [SLOT_FLD_W-1:0] out_from_ff;
   logic [SLOT_FLD_W-1:0] out_to_ff;
   logic                  out_status_ff;

   logic [WIDE_W-1:0]     slot_wide;
   logic [SLOT_W-1:0]     slot_idx;
   logic [SLICE_W-1:0]    tick_inc;
   logic [CNT_W-1:0]      scan_inc;
   logic [SLOT_W-1:0]     scan_next;
   logic [SLOT_W-1:0]     rd_addr;
   logic [SLOT_W-1:0]     wr_addr;
   logic [STATE_W-1:0]    wr_data;
   logic [SLOT_FLD_W-1:0] cur_fld;

   assign slot_wide = WIDE_W'(slot_ff);
   assign slot_idx  = slot_wide[SLOT_W-1:0];
   assign tick_inc  = tick_ff + SLICE_W'(1);
   assign scan_inc  = CNT_W'(scan_ff) + CNT_W'(1);
   assign scan_next = (scan_inc >= task_count_ff) ? '0 : scan_inc[SLOT_W-1:0];
   assign rd_addr   = (cmd.rd_src == RD_CUR) ? cur_ff : scan_next;
   assign cur_fld   = SLOT_FLD_W'(cur_ff);

   always_comb begin
      sts.req_type       = req_type_ff;
      sts.full           = (task_count_ff == CNT_W'(TASK_SLOTS));
      sts.empty          = (task_count_ff == '0);
      sts.slot_ok        = (slot_wide < WIDE_W'(TASK_SLOTS));
      sts.running        = run_ff;
      sts.tick_expire    = (tick_inc >= slice_ff);
      sts.can_sched      = (task_count_ff > CNT_W'(1)) && (CNT_W'(cur_ff) < task_count_ff);
      sts.scan_wraps_cur = (scan_next == cur_ff);
      sts.rd_dead        = (rd_data_ff == ST_DEAD);
      sts.rd_running     = (rd_data_ff == ST_RUNNING);
      sts.out_free       = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      wr_addr = cur_ff;
      wr_data = ST_READY;
      unique case (cmd.wr_sel)
         WR_ADD: begin
            wr_addr = task_count_ff[SLOT_W-1:0];
            wr_data = new_state_ff;
         end
         WR_SET: begin
            wr_addr = slot_idx;
            wr_data = new_state_ff;
         end
         WR_START: begin
            wr_addr = '0;
            wr_data = ST_RUNNING;
         end
         WR_PREV_READY: begin
            wr_addr = cur_ff;
            wr_data = ST_READY;
         end
         WR_NEXT_RUN: begin
            wr_addr = scan_ff;
            wr_data = ST_RUNNING;
         end
         default: begin
            wr_addr = cur_ff;
            wr_data = ST_READY;
         end
      endcase
   end

   // task table: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         slot_state_mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= slot_state_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_type_ff  <= req_type;
         slot_ff      <= req_slot;
         new_state_ff <= req_new_state;
      end
      if (cmd.scan_init) begin
         scan_ff <= cur_ff;
      end else if (cmd.scan_adv) begin
         scan_ff <= scan_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         task_count_ff <= '0;
         cur_ff        <= '0;
         tick_ff       <= '0;
         run_ff        <= 1'b0;
         slice_ff      <= SLICE_RESET;
      end else begin
         if (csr_wr_en) begin
            slice_ff <= csr_wr_data;
         end
         if (cmd.wr_en && (cmd.wr_sel == WR_ADD)) begin
            task_count_ff <= task_count_ff + CNT_W'(1);
         end
         if (cmd.tick_upd) begin
            tick_ff <= sts.tick_expire ? '0 : tick_inc;
         end
         if (cmd.start_upd) begin
            run_ff <= 1'b1;
            cur_ff <= '0;
         end else if (cmd.commit) begin
            cur_ff <= scan_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.res_en) begin
         res_kind_ff   <= KIND_NONE;
         res_from_ff   <= '0;
         res_to_ff     <= '0;
         res_status_ff <= 1'b0;
         unique case (cmd.res_sel)
            RES_IGNORE: begin
               res_status_ff <= 1'b1;
            end
            RES_ADD: begin
               res_to_ff <= SLOT_FLD_W'(task_count_ff);
            end
            RES_START: begin
               res_kind_ff <= KIND_START;
               res_from_ff <= cur_fld;
            end
            RES_HOLD: begin
               res_from_ff <= cur_fld;
               res_to_ff   <= cur_fld;
            end
            RES_SET: begin
               res_to_ff <= slot_ff;
            end
            RES_SWITCH: begin
               res_kind_ff <= KIND_SWITCH;
               res_from_ff <= cur_fld;
               res_to_ff   <= SLOT_FLD_W'(scan_ff);
            end
            default: begin
               res_status_ff <= 1'b1;
            end
         endcase
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.push) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         out_kind_ff   <= res_kind_ff;
         out_from_ff   <= res_from_ff;
         out_to_ff     <= res_to_ff;
         out_status_ff <= res_status_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_kind = out_kind_ff;
   assign rsp_from_slot  = out_from_ff;
   assign rsp_to_slot    = out_to_ff;
   assign rsp_status     = out_status_ff;

endmodule

FILE: hdl/round_robin_time_slice_scheduler.sv
// Round-robin time-slice scheduler, top level.
// Depends on rrts_pkg, rrts_ifs (channels), rrts_ctrl and rrts_dpath.
//
// Usage:
//   req_ch  : requests (req_type, slot, new_state), valid/ready.
//   rsp_ch  : one result item per request (event_kind, from_slot,
//             to_slot, status), valid/ready, from an output register.
//   csr_wr_en / csr_wr_data : write of the time-slice length in ticks.
// Add, start, set state, ignored requests and ticks that do not end the
//   slice pass through S_DECODE and S_FINISH before rsp_ch.valid rises;
//   the next request is taken once the controller is back in S_IDLE.
// A reschedule walks the task table through its single read port, with a
//   read step and a check step per slot visited, then on a switch fixes the
//   old and new slots (S_PREV_CHK, S_COMMIT).
// One item is in work at a time; the next is accepted while the previous
//   result still waits in the output register.
// If rsp_ch is stalled, the finished result is held in the staging register
//   and req_ch.ready stays low until the output register frees up.
// Reset (synchronous, active high) clears task count, current slot, tick
//   count and started flag and sets the slice to 10 ticks; the task table
//   itself is not cleared.
module round_robin_time_slice_scheduler (
   input  logic                         clock,
   input  logic                         reset,
   rrts_req_if.sink                     req_ch,
   rrts_rsp_if.source                   rsp_ch,
   input  logic                         csr_wr_en,
   input  logic [rrts_pkg::SLICE_W-1:0] csr_wr_data
);
   import rrts_pkg::*;

   cmd_type cmd;
   sts_type sts;

   rrts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rrts_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .req_type       (req_ch.req_type),
      .req_slot       (req_ch.slot),
      .req_new_state  (req_ch.new_state),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_ready      (rsp_ch.ready),
      .rsp_valid      (rsp_ch.valid),
      .rsp_event_kind (rsp_ch.event_kind),
      .rsp_from_slot  (rsp_ch.from_slot),
      .rsp_to_slot    (rsp_ch.to_slot),
      .rsp_status     (rsp_ch.status)
   );

`ifndef NO_ASSERTIONS
   // one item in work at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("request accepted while previous item in work");

   // a result is never pushed into an occupied, stalled output register
   a_push_free: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> (!rsp_ch.valid || rsp_ch.ready))
      else $error("result pushed over a pending result");

   // the new running slot is written together with the current-slot update
   a_commit_write: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (cmd.wr_en && (cmd.wr_sel == WR_NEXT_RUN)))
      else $error("commit without marking new slot running");

   // the scan never steps onto the current slot
   a_scan_stop: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_adv |-> !sts.scan_wraps_cur)
      else $error("scan advanced onto current slot");
`endif

endmodule
